[rtl/rmts_pkg.sv]
// Shared types and constants for the rate-monotonic tick scheduler.
`default_nettype none

package rmts_pkg;

   localparam int MAX_TASKS  = 16;
   localparam int TIME_BITS  = 16;
   localparam int IDX_BITS   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int SLOT_BITS  = 4;
   localparam int FIELD_BITS = 16;
   localparam int ACT_BITS   = 5;
   localparam int GRANT_BITS = 5;

   // tdata widths: slot, budget, period packed from bit 0, padded to bytes
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 8;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   typedef logic [TIME_BITS-1:0] time_type;

   // One decoded transaction, presented to the slot bank for a single cycle
   typedef struct packed {
      logic                 tick;
      logic                 load;
      logic [SLOT_BITS-1:0] slot;
      time_type             budget;
      time_type             period;
   } op_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] idx;
   } grant_type;

endpackage : rmts_pkg

`default_nettype wire

[rtl/rmts_min_tree.sv]
// Balanced compare tree picking the ready slot with the shortest period.
`default_nettype none

module rmts_min_tree (
   input  var logic                           ready_vec [rmts_pkg::MAX_TASKS],
   input  var logic [rmts_pkg::TIME_BITS-1:0] period_vec [rmts_pkg::MAX_TASKS],
   output var rmts_pkg::grant_type            grant
);
   import rmts_pkg::*;

   localparam int LEVELS = IDX_BITS;
   localparam int LEAVES = 1 << LEVELS;

   logic                node_vld [1:2*LEAVES-1];
   time_type            node_per [1:2*LEAVES-1];
   logic [IDX_BITS-1:0] node_idx [1:2*LEAVES-1];

   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         if (i < MAX_TASKS) begin
            node_vld[LEAVES+i] = ready_vec[i];
            node_per[LEAVES+i] = period_vec[i];
         end else begin
            node_vld[LEAVES+i] = 1'b0;
            node_per[LEAVES+i] = '0;
         end
         node_idx[LEAVES+i] = IDX_BITS'(i);
      end
      // left child wins ties, so the lower slot is kept on equal periods
      for (int n = LEAVES - 1; n >= 1; n--) begin
         if (node_vld[2*n+1] && (!node_vld[2*n] || node_per[2*n+1] < node_per[2*n])) begin
            node_vld[n] = 1'b1;
            node_per[n] = node_per[2*n+1];
            node_idx[n] = node_idx[2*n+1];
         end else begin
            node_vld[n] = node_vld[2*n];
            node_per[n] = node_per[2*n];
            node_idx[n] = node_idx[2*n];
         end
      end
   end

   assign grant.found = node_vld[1];
   assign grant.idx   = node_idx[1];

endmodule : rmts_min_tree

`default_nettype wire

[rtl/rmts_slot_bank.sv]
// Per-slot task state: budget, period, remaining work and period countdown.
`default_nettype none

module rmts_slot_bank (
   input  var logic                          clock,
   input  var logic                          reset,
   input  var rmts_pkg::op_type              op,
   input  var logic [rmts_pkg::ACT_BITS-1:0] active_tasks,
   output var rmts_pkg::grant_type           grant
);
   import rmts_pkg::*;

   time_type budget_ff    [MAX_TASKS];
   time_type budget_in    [MAX_TASKS];
   time_type period_ff    [MAX_TASKS];
   time_type period_in    [MAX_TASKS];
   time_type remaining_ff [MAX_TASKS];
   time_type remaining_in [MAX_TASKS];
   time_type countdown_ff [MAX_TASKS];
   time_type countdown_in [MAX_TASKS];

   logic     part_vec  [MAX_TASKS];
   logic     ready_vec [MAX_TASKS];

   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         part_vec[i]  = 32'(i) < 32'(active_tasks);
         ready_vec[i] = part_vec[i] && (remaining_ff[i] != '0);
      end
   end

   rmts_min_tree u_min_tree (
      .ready_vec  (ready_vec),
      .period_vec (period_ff),
      .grant      (grant)
   );

   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         budget_in[i]    = budget_ff[i];
         period_in[i]    = period_ff[i];
         remaining_in[i] = remaining_ff[i];
         countdown_in[i] = countdown_ff[i];
         if (op.load && 32'(op.slot) == 32'(i)) begin
            budget_in[i]    = op.budget;
            period_in[i]    = op.period;
            remaining_in[i] = op.budget;
            countdown_in[i] = op.period;
         end
         if (op.tick) begin
            if (grant.found && grant.idx == IDX_BITS'(i)) begin
               remaining_in[i] = remaining_ff[i] - time_type'(1);
            end
            // period expiry overrides the grant and drops unfinished work
            if (part_vec[i]) begin
               if (countdown_ff[i] <= time_type'(1)) begin
                  remaining_in[i] = budget_ff[i];
                  countdown_in[i] = period_ff[i];
               end else begin
                  countdown_in[i] = countdown_ff[i] - time_type'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            budget_ff[i]    <= '0;
            period_ff[i]    <= time_type'(1);
            remaining_ff[i] <= '0;
            countdown_ff[i] <= time_type'(1);
         end
      end else begin
         budget_ff    <= budget_in;
         period_ff    <= period_in;
         remaining_ff <= remaining_in;
         countdown_ff <= countdown_in;
      end
   end

   a_grant_is_ready : assert property (@(posedge clock) disable iff (reset)
      grant.found |-> ready_vec[grant.idx])
      else $error("granted slot is not ready");

   a_grant_decrements : assert property (@(posedge clock) disable iff (reset)
      op.tick && grant.found && countdown_ff[grant.idx] > time_type'(1)
      |=> remaining_ff[$past(grant.idx)] == $past(remaining_ff[grant.idx]) - time_type'(1))
      else $error("granted slot did not lose one unit of work");

endmodule : rmts_slot_bank

`default_nettype wire

[rtl/rate_monotonic_tick_scheduler_unit.sv]
// Top level of the rate-monotonic tick scheduler: stream ports, staging, result register.
// A transaction is registered in the input stage on acceptance and evaluated there once it may
//   proceed; a tick's result is then registered into the result register that drives rsp_.
// Throughput: one transaction per cycle while ticks find the result register free; the compare tree is combinational.
// Loads produce no result and never wait on the result register.
// Reset (synchronous, active high) clears the pipeline valids, sets active_tasks to 1,
//   all budgets and remaining work to 0 and all periods and countdowns to 1.
`default_nettype none

module rate_monotonic_tick_scheduler_unit (
   input  var logic                               clock,
   input  var logic                               reset,
   // request channel
   input  var logic                               req_tvalid,
   output var logic                               req_tready,
   // tdata: [3:0] task_slot, [19:4] task_budget, [35:20] task_period, [39:36] zero
   input  var logic [rmts_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // tuser: [0] req_type
   input  var logic [0:0]                         req_tuser,
   // response channel
   output var logic                               rsp_tvalid,
   input  var logic                               rsp_tready,
   // tdata: [4:0] granted_task, [7:5] zero
   output var logic [rmts_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // configuration
   input  var logic                               csr_wr_en,
   input  var logic [rmts_pkg::ACT_BITS-1:0]      csr_wr_data
);
   import rmts_pkg::*;

   // input stage
   logic                  in_valid_ff;
   logic                  in_valid_in;
   req_kind_type          in_kind_ff;
   logic [SLOT_BITS-1:0]  in_slot_ff;
   logic [FIELD_BITS-1:0] in_budget_ff;
   logic [FIELD_BITS-1:0] in_period_ff;

   // result stage
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [GRANT_BITS-1:0] out_grant_ff;
   logic [GRANT_BITS-1:0] out_grant_in;

   logic [ACT_BITS-1:0]   active_tasks_ff;

   logic                  out_free;
   logic                  proceed;
   logic                  req_fire;
   op_type                op;
   grant_type             grant;
   time_type              period_trunc;

   // result register can take a new grant when empty or being drained
   assign out_free   = !out_valid_ff || rsp_tready;
   assign proceed    = in_valid_ff && (in_kind_ff == REQ_LOAD || out_free);
   assign req_tready = !in_valid_ff || proceed;
   assign req_fire   = req_tvalid && req_tready;

   // fields cut or widened to the time width; a zero period is stored as one
   assign period_trunc = time_type'(in_period_ff);

   always_comb begin
      op.tick   = proceed && in_kind_ff == REQ_TICK;
      op.load   = proceed && in_kind_ff == REQ_LOAD;
      op.slot   = in_slot_ff;
      op.budget = time_type'(in_budget_ff);
      op.period = (period_trunc == '0) ? time_type'(1) : period_trunc;
   end

   rmts_slot_bank u_slot_bank (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .active_tasks (active_tasks_ff),
      .grant        (grant)
   );

   always_comb begin
      in_valid_in  = req_fire || (in_valid_ff && !proceed);
      out_valid_in = out_valid_ff && !rsp_tready;
      out_grant_in = out_grant_ff;
      if (op.tick) begin
         out_valid_in = 1'b1;
         out_grant_in = grant.found ? GRANT_BITS'(32'(grant.idx) + 32'd1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         active_tasks_ff <= ACT_BITS'(1);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            active_tasks_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff   <= req_kind_type'(req_tuser[0]);
         in_slot_ff   <= req_tdata[SLOT_BITS-1:0];
         in_budget_ff <= req_tdata[SLOT_BITS +: FIELD_BITS];
         in_period_ff <= req_tdata[SLOT_BITS+FIELD_BITS +: FIELD_BITS];
      end
      out_grant_ff <= out_grant_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(out_grant_ff);

   a_tick_gives_result : assert property (@(posedge clock) disable iff (reset)
      op.tick |=> out_valid_ff)
      else $error("processed tick left no result");

   a_load_no_result : assert property (@(posedge clock) disable iff (reset)
      op.load |=> out_valid_ff == $past(out_valid_ff && !rsp_tready))
      else $error("load transaction changed the result register");

   a_stall_holds_stage : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proceed |=> in_valid_ff && $stable(in_slot_ff) && $stable(in_kind_ff))
      else $error("stalled input stage lost its transaction");

endmodule : rate_monotonic_tick_scheduler_unit

`default_nettype wire
